@@ design/mbrp_pkg.sv @@
// ---------------------------------------------------------------------------
// Modbus read response parser package
// Shared codes, command and status bundles and the CRC-16 byte fold used by
// the parser controller and datapath.
// ---------------------------------------------------------------------------
package mbrp_pkg;

  // Function codes of a read input registers reply.
  localparam logic [7:0] FN_READ_INPUT = 8'h04;
  localparam logic [7:0] FN_EXCEPTION  = 8'h84;

  // CRC-16 constants.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Frame status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXCEPTION = 2'd1;
  localparam logic [1:0] ST_BAD       = 2'd2;

  // Item kinds.
  localparam logic KIND_WORD   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Controller states. The first six double as the parse phase.
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_FUNC      = 4'd1;
  localparam logic [3:0] S_COUNT     = 4'd2;
  localparam logic [3:0] S_DATA      = 4'd3;
  localparam logic [3:0] S_CRC_LO    = 4'd4;
  localparam logic [3:0] S_CRC_HI    = 4'd5;
  localparam logic [3:0] S_EMIT_ADDR = 4'd6;
  localparam logic [3:0] S_EMIT_DATA = 4'd7;
  localparam logic [3:0] S_EMIT_STAT = 4'd8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       take;         // input word accepted this cycle
    logic       start;        // accepted word opens a new frame
    logic [3:0] phase;        // parse phase the word belongs to
    logic       load_word;    // load a register word into the output stage
    logic       load_status;  // load a status item into the output stage
    logic [1:0] status_code;  // status of that item
  } mbrp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic func_known;   // byte is a valid function code
    logic is_exc;       // frame is an exception reply
    logic count_bad;    // byte count is too large
    logic count_zero;   // byte count is zero
    logic data_last;    // byte is the last data byte
    logic crc_ok;       // received CRC matches the running CRC
    logic total_zero;   // reply holds no register words
    logic idx_last;     // word being emitted is the last one
    logic out_free;     // output stage can take a new item
  } mbrp_sts_t;

  // Fold one byte into a reflected CRC-16.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                           input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ design/mbrp_ram.sv @@
// ---------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module mbrp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/mbrp_ctrl.sv @@
// ---------------------------------------------------------------------------
// Modbus read response parser controller
// Tracks the parse phase of the current frame and sequences the emission of
// buffered register words and the closing status item.
// ---------------------------------------------------------------------------
module mbrp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_start,
  output logic               in_ready,
  input  mbrp_pkg::mbrp_sts_t sts,
  output mbrp_pkg::mbrp_cmd_t cmd
);
  import mbrp_pkg::*;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       parsing;
  logic       take;

  // Bytes are taken in any parse phase while the output stage has room.
  assign parsing  = (state inside {S_IDLE, S_FUNC, S_COUNT, S_DATA, S_CRC_LO, S_CRC_HI});
  assign in_ready = parsing && sts.out_free;
  assign take     = in_valid && in_ready;

  // Next state and datapath commands.
  always_comb begin
    state_next          = state;
    cmd.take            = take;
    cmd.start           = take && in_start;
    cmd.phase           = state;
    cmd.load_word       = 1'b0;
    cmd.load_status     = 1'b0;
    cmd.status_code     = ST_OK;
    if (take && in_start) begin
      state_next = S_FUNC;
    end else begin
      case (state)
        S_FUNC: begin
          if (take) begin
            if (!sts.func_known) begin
              cmd.load_status = 1'b1;
              cmd.status_code = ST_BAD;
              state_next      = S_IDLE;
            end else begin
              state_next = S_COUNT;
            end
          end
        end
        S_COUNT: begin
          if (take) begin
            if (sts.is_exc) begin
              state_next = S_CRC_LO;
            end else if (sts.count_bad) begin
              cmd.load_status = 1'b1;
              cmd.status_code = ST_BAD;
              state_next      = S_IDLE;
            end else if (sts.count_zero) begin
              state_next = S_CRC_LO;
            end else begin
              state_next = S_DATA;
            end
          end
        end
        S_DATA: begin
          if (take && sts.data_last) begin
            state_next = S_CRC_LO;
          end
        end
        S_CRC_LO: begin
          if (take) begin
            state_next = S_CRC_HI;
          end
        end
        S_CRC_HI: begin
          if (take) begin
            if (!sts.crc_ok) begin
              cmd.load_status = 1'b1;
              cmd.status_code = ST_BAD;
              state_next      = S_IDLE;
            end else if (sts.is_exc) begin
              cmd.load_status = 1'b1;
              cmd.status_code = ST_EXCEPTION;
              state_next      = S_IDLE;
            end else if (sts.total_zero) begin
              cmd.load_status = 1'b1;
              cmd.status_code = ST_OK;
              state_next      = S_IDLE;
            end else begin
              state_next = S_EMIT_ADDR;
            end
          end
        end
        S_EMIT_ADDR: begin
          state_next = S_EMIT_DATA;
        end
        S_EMIT_DATA: begin
          if (sts.out_free) begin
            cmd.load_word = 1'b1;
            state_next    = sts.idx_last ? S_EMIT_STAT : S_EMIT_ADDR;
          end
        end
        S_EMIT_STAT: begin
          if (sts.out_free) begin
            cmd.load_status = 1'b1;
            cmd.status_code = ST_OK;
            state_next      = S_IDLE;
          end
        end
        default: begin
          state_next = state;
        end
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ design/mbrp_datapath.sv @@
// ---------------------------------------------------------------------------
// Modbus read response parser datapath
// Holds the running CRC, byte position, frame fields and the register word
// buffer, and drives the output stage.
// ---------------------------------------------------------------------------
module mbrp_datapath #(
  parameter int MAX_REGISTERS   = 32,
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          rx_byte,
  input  mbrp_pkg::mbrp_cmd_t cmd,
  output mbrp_pkg::mbrp_sts_t sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [55:0]         out_data,
  output logic                out_kind,
  output logic                out_last
);
  import mbrp_pkg::*;

  localparam int         AW        = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1;
  localparam logic [9:0] MAX_COUNT = 10'(2 * MAX_REGISTERS);
  localparam logic [9:0] MAX_BYTES = 10'(MAX_FRAME_BYTES);
  localparam logic [7:0] MAX_WORDS = 8'(MAX_REGISTERS);

  logic [15:0] crc;
  logic [8:0]  pos;
  logic [7:0]  count;
  logic        is_exc;
  logic [7:0]  held;
  logic [7:0]  frame_addr;
  logic [7:0]  exc_code;
  logic [5:0]  total;
  logic [5:0]  idx;

  logic [8:0]  off;
  logic [8:0]  pos_inc;
  logic [15:0] crc_new;
  logic [5:0]  total_new;
  logic        step;
  logic        ram_we;
  logic [15:0] ram_rdata;

  // Output stage fields.
  logic [1:0]  o_status;
  logic [7:0]  o_exc;
  logic [7:0]  o_addr;
  logic [5:0]  o_idx;
  logic [15:0] o_val;
  logic [5:0]  o_total;
  logic [8:0]  o_flen;

  // Per-byte arithmetic.
  assign step    = cmd.take && !cmd.start;
  assign off     = pos - 9'd3;
  assign pos_inc = pos + 9'd1;
  assign crc_new = crc_fold(crc, rx_byte);
  assign total_new = ({1'b0, rx_byte[7:1]} > MAX_WORDS) ? MAX_WORDS[5:0] : rx_byte[6:1];

  // Status toward the controller.
  always_comb begin
    sts.func_known = rx_byte inside {FN_READ_INPUT, FN_EXCEPTION};
    sts.is_exc     = is_exc;
    sts.count_bad  = ({2'b00, rx_byte} > MAX_COUNT) ||
                     ((10'd5 + {2'b00, rx_byte}) > MAX_BYTES);
    sts.count_zero = (rx_byte == 8'd0);
    sts.data_last  = ((off + 9'd1) >= {1'b0, count});
    sts.crc_ok     = ({rx_byte, held} == crc);
    sts.total_zero = (total == 6'd0);
    sts.idx_last   = ((idx + 6'd1) == total);
    sts.out_free   = !out_valid || out_ready;
  end

  // Frame state updated by each accepted byte, and the word index by each emitted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc        <= CRC_INIT;
      pos        <= 9'd0;
      count      <= 8'd0;
      is_exc     <= 1'b0;
      held       <= 8'd0;
      frame_addr <= 8'd0;
      exc_code   <= 8'd0;
      total      <= 6'd0;
      idx        <= 6'd0;
    end else if (cmd.start) begin
      frame_addr <= rx_byte;
      crc        <= crc_fold(CRC_INIT, rx_byte);
      pos        <= 9'd1;
      count      <= 8'd0;
      is_exc     <= 1'b0;
      held       <= 8'd0;
      exc_code   <= 8'd0;
      total      <= 6'd0;
      idx        <= 6'd0;
    end else begin
      if (step) begin
        case (cmd.phase)
          S_FUNC: begin
            pos <= pos_inc;
            crc <= crc_new;
            if (rx_byte == FN_EXCEPTION) begin
              is_exc <= 1'b1;
            end
          end
          S_COUNT: begin
            pos <= pos_inc;
            crc <= crc_new;
            if (is_exc) begin
              exc_code <= rx_byte;
            end else begin
              count <= rx_byte;
              total <= total_new;
            end
          end
          S_DATA: begin
            pos <= pos_inc;
            crc <= crc_new;
            if (!off[0]) begin
              held <= rx_byte;
            end
          end
          S_CRC_LO: begin
            pos  <= pos_inc;
            held <= rx_byte;
          end
          S_CRC_HI: begin
            pos <= pos_inc;
          end
          default: begin
            pos <= pos;
          end
        endcase
      end
      if (cmd.load_word) begin
        idx <= idx + 6'd1;
      end
    end
  end

  // Register word buffer: odd data bytes complete a word.
  assign ram_we = step && (cmd.phase == S_DATA) && off[0] &&
                  ({1'b0, off[8:1]} < {1'b0, MAX_WORDS});

  mbrp_ram #(
    .WIDTH (16),
    .DEPTH (MAX_REGISTERS)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (off[AW:1]),
    .wdata ({held, rx_byte}),
    .raddr (idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Output stage valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_word || cmd.load_status) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output stage payload.
  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      out_kind <= KIND_WORD;
      out_last <= 1'b0;
      o_status <= ST_OK;
      o_exc    <= 8'd0;
      o_addr   <= frame_addr;
      o_idx    <= idx;
      o_val    <= ram_rdata;
      o_total  <= total;
      o_flen   <= pos;
    end else if (cmd.load_status) begin
      out_kind <= KIND_STATUS;
      out_last <= 1'b1;
      o_status <= cmd.status_code;
      o_exc    <= (cmd.status_code == ST_EXCEPTION) ? exc_code : 8'd0;
      o_addr   <= frame_addr;
      o_idx    <= 6'd0;
      o_val    <= 16'd0;
      o_total  <= (cmd.status_code == ST_OK) ? total : 6'd0;
      if (cmd.status_code == ST_BAD) begin
        o_flen <= 9'd0;
      end else begin
        o_flen <= cmd.take ? pos_inc : pos;
      end
    end
  end

  assign out_data = {1'b0, o_flen, o_total, o_val, o_idx, o_addr, o_exc, o_status};

endmodule

@@ design/modbus_read_response_parser_unit.sv @@
// ---------------------------------------------------------------------------
// Modbus RTU read input registers response parser
// Output: a status item for a frame with no register words is registered
// in the cycle after the byte that ends the frame; a register word is read
// from the RAM in the address state and loaded in the data state. Throughput:
// one byte per cycle while parsing and the output register is free; input is
// held off while the words and status item go out, longer while output stalls.
// Reset: synchronous, clears the parser to idle and empties the output.
// ---------------------------------------------------------------------------
module modbus_read_response_parser_unit #(
  parameter int MAX_REGISTERS   = 32,
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  input  logic        s_axis_tuser,   // frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], exception code[9:2], slave address[17:10],
  // register_index[23:18], register_value[39:24], register_total[45:40],
  // frame length[54:46], zero pad[55]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tuser,   // item_kind
  output logic        m_axis_tlast    // last_item
);
  import mbrp_pkg::*;

  mbrp_cmd_t cmd;
  mbrp_sts_t sts;

  // Frame controller.
  mbrp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_start (s_axis_tuser),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // CRC, frame fields, word buffer and output stage.
  mbrp_datapath #(
    .MAX_REGISTERS   (MAX_REGISTERS),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (s_axis_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_kind  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule

@@ sim/tb_modbus_read_response_parser_unit.sv @@
// ---------------------------------------------------------------------------
// Testbench for the Modbus RTU read response parser
// Frames are sent one byte per word. A byte-level predictor tracks the parse
// state and the CRC-16 and queues the register words and status items that
// each byte should produce. A checker compares every output word field by
// field against that queue. Directed frames come first, then random traffic
// under three stall profiles.
// ---------------------------------------------------------------------------
module tb_modbus_read_response_parser_unit;
  import mbrp_pkg::*;

  localparam int MAX_REGS     = 32;
  localparam int MAX_FRAME    = 256;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 2 * MAX_REGS + 8;
  localparam int MAX_PRINTED  = 40;

  typedef logic [7:0] byte_q_t[$];

  // Parse position of the predictor.
  typedef enum logic [2:0] {
    AWAIT_START, AT_FUNC, AT_COUNT, AT_DATA, AT_CRC_LO, AT_CRC_HI, FRAME_DONE
  } rx_phase_e;

  // Shapes of random frames.
  typedef enum logic [2:0] {
    GOOD_READ, EXC_REPLY, BAD_FUNC, BIG_COUNT, BAD_CRC, CUT_SHORT
  } frame_kind_e;

  // One output word as the parser should deliver it.
  typedef struct {
    logic        kind;
    logic [1:0]  status;
    logic [7:0]  exc_code;
    logic [7:0]  addr;
    logic [5:0]  reg_index;
    logic [15:0] reg_value;
    logic [5:0]  reg_total;
    logic [8:0]  byte_len;
    logic        last;
  } reply_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  int sender_idle_pct  = 14;
  int sink_stall_pct   = 62;
  int quiet_cycles     = 0;
  int error_count      = 0;
  int bytes_sent       = 0;
  int frames_cut       = 0;
  int words_seen       = 0;
  int ok_frames        = 0;
  int exc_frames       = 0;
  int bad_frames       = 0;

  reply_item_t pending_items[$];

  // Predictor state.
  rx_phase_e   rx_phase = AWAIT_START;
  logic [15:0] rx_crc = CRC_INIT;
  logic [8:0]  rx_pos = '0;
  logic [7:0]  rx_count = '0;
  logic        rx_is_exc = 1'b0;
  logic [7:0]  rx_held = '0;
  logic [7:0]  rx_addr = '0;
  logic [7:0]  rx_exc_code = '0;
  logic [15:0] rx_words [MAX_REGS];

  modbus_read_response_parser_unit #(
    .MAX_REGISTERS  (MAX_REGS),
    .MAX_FRAME_BYTES(MAX_FRAME)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // Clock with an 8 unit period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bit-serial reflected CRC-16, one data bit per step.
  function automatic logic [15:0] crc16_step(input logic [15:0] seed, input logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = seed;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ data[i];
      r = r >> 1;
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  function automatic void queue_item(input logic kind, input logic [1:0] status,
                                     input logic [7:0] exc, input logic [5:0] idx,
                                     input logic [15:0] val, input logic [5:0] tot,
                                     input logic [8:0] flen);
    reply_item_t it;
    it.kind      = kind;
    it.status    = status;
    it.exc_code  = exc;
    it.addr      = rx_addr;
    it.reg_index = idx;
    it.reg_value = val;
    it.reg_total = tot;
    it.byte_len  = flen;
    it.last      = (kind == KIND_STATUS);
    pending_items.push_back(it);
  endfunction

  // Advance the predictor by one accepted byte and queue what it produces.
  function automatic void parse_rx_byte(input logic [7:0] b, input logic first);
    logic [8:0]  off;
    logic [5:0]  total;
    logic [15:0] got_crc;
    if (first) begin
      rx_addr     = b;
      rx_crc      = crc16_step(CRC_INIT, b);
      rx_pos      = 9'd1;
      rx_count    = '0;
      rx_is_exc   = 1'b0;
      rx_held     = '0;
      rx_exc_code = '0;
      rx_phase    = AT_FUNC;
    end else begin
      case (rx_phase)
        AT_FUNC: begin
          rx_pos = rx_pos + 9'd1;
          if (b != FN_READ_INPUT && b != FN_EXCEPTION) begin
            queue_item(KIND_STATUS, ST_BAD, '0, '0, '0, '0, '0);
            rx_phase = FRAME_DONE;
          end else begin
            rx_is_exc = (b == FN_EXCEPTION);
            rx_crc    = crc16_step(rx_crc, b);
            rx_phase  = AT_COUNT;
          end
        end
        AT_COUNT: begin
          rx_pos = rx_pos + 9'd1;
          rx_crc = crc16_step(rx_crc, b);
          if (rx_is_exc) begin
            rx_exc_code = b;
            rx_phase    = AT_CRC_LO;
          end else if (int'(b) > 2 * MAX_REGS || 5 + int'(b) > MAX_FRAME) begin
            queue_item(KIND_STATUS, ST_BAD, '0, '0, '0, '0, '0);
            rx_phase = FRAME_DONE;
          end else begin
            rx_count = b;
            rx_phase = (b == 8'd0) ? AT_CRC_LO : AT_DATA;
          end
        end
        AT_DATA: begin
          off    = rx_pos - 9'd3;
          rx_pos = rx_pos + 9'd1;
          rx_crc = crc16_step(rx_crc, b);
          if (off[0]) begin
            rx_words[off >> 1] = {rx_held, b};
          end else begin
            rx_held = b;
          end
          if (off + 9'd1 >= {1'b0, rx_count}) begin
            rx_phase = AT_CRC_LO;
          end
        end
        AT_CRC_LO: begin
          rx_pos   = rx_pos + 9'd1;
          rx_held  = b;
          rx_phase = AT_CRC_HI;
        end
        AT_CRC_HI: begin
          rx_pos   = rx_pos + 9'd1;
          got_crc  = {b, rx_held};
          rx_phase = FRAME_DONE;
          if (got_crc != rx_crc) begin
            queue_item(KIND_STATUS, ST_BAD, '0, '0, '0, '0, '0);
          end else if (rx_is_exc) begin
            queue_item(KIND_STATUS, ST_EXCEPTION, rx_exc_code, '0, '0, '0, rx_pos);
          end else begin
            total = rx_count[6:1];
            for (int i = 0; i < int'(total); i++) begin
              queue_item(KIND_WORD, ST_OK, '0, 6'(i), rx_words[i], total, rx_pos);
            end
            queue_item(KIND_STATUS, ST_OK, '0, '0, '0, total, rx_pos);
          end
        end
        default: begin
          // Idle or finished frame: byte is dropped.
        end
      endcase
    end
  endfunction

  // Append the two CRC bytes, low byte first.
  function automatic byte_q_t with_crc(input byte_q_t q);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (q[i]) c = crc16_step(c, q[i]);
    q.push_back(c[7:0]);
    q.push_back(c[15:8]);
    return q;
  endfunction

  // Build a normal reply; a negative fill gives random data bytes.
  function automatic byte_q_t read_reply(input logic [7:0] addr, input int count,
                                         input int fill);
    byte_q_t q;
    q.push_back(addr);
    q.push_back(FN_READ_INPUT);
    q.push_back(8'(count));
    for (int i = 0; i < count; i++) begin
      q.push_back((fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
    end
    return with_crc(q);
  endfunction

  function automatic byte_q_t exception_reply(input logic [7:0] addr, input logic [7:0] code);
    byte_q_t q;
    q.push_back(addr);
    q.push_back(FN_EXCEPTION);
    q.push_back(code);
    return with_crc(q);
  endfunction

  // Drive one byte and wait for it to be taken. Valid is only dropped while
  // the sender idles, so back-to-back bytes keep it high.
  task automatic send_byte(input logic [7:0] value, input logic first);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= first;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    parse_rx_byte(value, first);
    bytes_sent++;
  endtask

  task automatic send_frame(input byte_q_t q);
    foreach (q[i]) send_byte(q[i], i == 0);
  endtask

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      report_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
    end
  endtask

  // Compare one accepted output word with the oldest expectation.
  task automatic check_reply_item();
    reply_item_t want;
    if (pending_items.size() == 0) begin
      report_mismatch($sformatf("unexpected word, tdata=%h", m_axis_tdata));
    end else begin
      want = pending_items.pop_front();
      compare_field("item kind", want.kind, m_axis_tuser);
      compare_field("status", want.status, m_axis_tdata[1:0]);
      compare_field("exception code", want.exc_code, m_axis_tdata[9:2]);
      compare_field("slave address", want.addr, m_axis_tdata[17:10]);
      compare_field("register index", want.reg_index, m_axis_tdata[23:18]);
      compare_field("register value", want.reg_value, m_axis_tdata[39:24]);
      compare_field("register total", want.reg_total, m_axis_tdata[45:40]);
      compare_field("frame length", want.byte_len, m_axis_tdata[54:46]);
      compare_field("last item", want.last, m_axis_tlast);
      if (want.kind == KIND_WORD) begin
        words_seen++;
      end else if (want.status == ST_OK) begin
        ok_frames++;
      end else if (want.status == ST_EXCEPTION) begin
        exc_frames++;
      end else begin
        bad_frames++;
      end
    end
  endtask

  // Output side: random backpressure.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      check_reply_item();
    end
  end

  // Count cycles in which neither side moves a word.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Timeout: no word moved for %0d cycles, %0d items outstanding",
             QUIET_LIMIT, pending_items.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Bytes without a frame start while idle are dropped.
  task automatic test_stray_bytes();
    send_byte(8'hA5, 1'b0);
  endtask

  // Zero count, odd count with extreme byte values, then a trailing byte.
  task automatic test_normal_replies();
    send_frame(read_reply(8'h00, 0, 0));
    send_frame(read_reply(8'hFF, 3, 8'hFF));
    send_byte(8'h00, 1'b0);
  endtask

  // A partial frame is abandoned by the next frame start.
  task automatic test_frame_cut();
    byte_q_t q;
    q = {8'h55, FN_READ_INPUT};
    send_frame(q);
    frames_cut++;
  endtask

  task automatic test_exception_reply();
    send_frame(exception_reply(8'h22, 8'h02));
  endtask

  // Unknown function, oversized count and corrupted CRC.
  task automatic test_bad_frames();
    byte_q_t q;
    q = {8'h33, 8'h03};
    send_frame(q);
    send_byte(FN_READ_INPUT, 1'b0);
    q = {8'h44, FN_READ_INPUT, 8'(2 * MAX_REGS + 1)};
    send_frame(q);
    q = read_reply(8'h5A, 0, 0);
    q[q.size() - 1] = q[q.size() - 1] ^ 8'h01;
    send_frame(q);
  endtask

  function automatic frame_kind_e pick_frame_kind();
    int r;
    r = $urandom_range(99);
    if (r < 60) return GOOD_READ;
    if (r < 70) return EXC_REPLY;
    if (r < 76) return BAD_FUNC;
    if (r < 82) return BIG_COUNT;
    if (r < 92) return BAD_CRC;
    return CUT_SHORT;
  endfunction

  // Mostly well-formed replies with random content, mixed with broken frames
  // and stray bytes, under one stall profile.
  task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                     input bit with_full_reply, input int min_bytes);
    byte_q_t     q;
    byte_q_t     cut;
    frame_kind_e kind;
    int          count;
    int          n;
    int          sent;
    int          frames;
    logic [7:0]  fn;
    sender_idle_pct = src_pct;
    sink_stall_pct  = sink_pct;
    sent   = 0;
    frames = 0;
    while (sent < min_bytes) begin
      kind  = pick_frame_kind();
      count = ($urandom_range(9) == 0) ? $urandom_range(9, 2 * MAX_REGS)
                                       : $urandom_range(0, 8);
      if (with_full_reply && frames == 0) begin
        kind  = GOOD_READ;
        count = 2 * MAX_REGS;
      end
      case (kind)
        GOOD_READ: q = read_reply(8'($urandom_range(255)), count, -1);
        EXC_REPLY: q = exception_reply(8'($urandom_range(255)), 8'($urandom_range(255)));
        BAD_FUNC: begin
          do fn = 8'($urandom_range(255));
          while (fn == FN_READ_INPUT || fn == FN_EXCEPTION);
          q = {8'($urandom_range(255)), fn};
        end
        BIG_COUNT: begin
          q = {8'($urandom_range(255)), FN_READ_INPUT,
               8'($urandom_range(2 * MAX_REGS + 1, 255))};
        end
        BAD_CRC: begin
          q = read_reply(8'($urandom_range(255)), count, -1);
          n = q.size() - 1 - $urandom_range(1);
          q[n] = q[n] ^ 8'($urandom_range(1, 255));
        end
        default: begin
          cut = read_reply(8'($urandom_range(255)), count, -1);
          n = $urandom_range(1, cut.size() - 1);
          q = cut[0:n-1];
          frames_cut++;
        end
      endcase
      send_frame(q);
      sent += q.size();
      frames++;
      // Stray bytes after a finished frame are dropped by the parser.
      if (kind != CUT_SHORT && $urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
      end
    end
  endtask

  // Test sequence.
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_stray_bytes();
    test_normal_replies();
    test_frame_cut();
    test_exception_reply();
    test_bad_frames();
    test_random_traffic(14, 62, 1'b1, 25);
    test_random_traffic(62, 14, 1'b0, 25);
    test_random_traffic(0, 0, 1'b0, 25);
    s_axis_tvalid <= 1'b0;
    while (pending_items.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_items.size() != 0) begin
      report_mismatch($sformatf("%0d expected items never arrived", pending_items.size()));
    end
    $display("Sent %0d bytes; %0d partial frames were cut off by a new start.",
             bytes_sent, frames_cut);
    $display("Checked %0d register words, %0d ok, %0d exception and %0d bad frames.",
             words_seen, ok_frames, exc_frames, bad_frames);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
